// ===== rtl/ipd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipd_pkg
// shared types and constants of the pulse-distance ir frame decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

   localparam int CFG_BITS       = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int KEY_BITS       = 32;
   localparam int COUNT_BITS     = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEADER_MIN    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEADER_MAX    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIT_THRESHOLD = 2'd2;

   localparam logic [CFG_BITS-1:0] LEADER_MIN_RESET    = 24'd1070000;
   localparam logic [CFG_BITS-1:0] LEADER_MAX_RESET    = 24'd1080000;
   localparam logic [CFG_BITS-1:0] BIT_THRESHOLD_RESET = 24'd170000;

   localparam logic [COUNT_BITS-1:0] COUNT_IDLE   = 6'd0;
   localparam logic [COUNT_BITS-1:0] COUNT_LEADER = 6'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_DATA   = 6'd2;

   typedef struct packed {
      logic [CFG_BITS-1:0] leader_min;
      logic [CFG_BITS-1:0] leader_max;
      logic [CFG_BITS-1:0] bit_threshold;
   } cfg_type;

   typedef struct packed {
      logic                  advance;
      logic                  emit;
      logic [COUNT_BITS-1:0] edge_count;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/ipd_if.sv =====
// ----------------------------------------------------------------------------
// ipd channel interfaces
// edge stamp request, key code response and register write channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ipd_req_if #(
   parameter int STAMP_BITS = 24
);
   logic                  valid;
   logic                  ready;
   logic [STAMP_BITS-1:0] edge_time;

   modport source (output valid, output edge_time, input ready);
   modport sink   (input valid, input edge_time, output ready);
endinterface

interface ipd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ipd_pkg::KEY_BITS-1:0] key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

interface ipd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ipd_pkg::CSR_INDEX_BITS-1:0] index;
   logic [ipd_pkg::CFG_BITS-1:0]       wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/ipd_csr.sv =====
// ----------------------------------------------------------------------------
// ipd_csr
// timing window and bit threshold registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipd_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   ipd_csr_if.sink               csr_chan,
   output ipd_pkg::cfg_type      cfg
);
   import ipd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_chan.index)
            CSR_LEADER_MIN:    cfg_in.leader_min    = csr_chan.wdata;
            CSR_LEADER_MAX:    cfg_in.leader_max    = csr_chan.wdata;
            CSR_BIT_THRESHOLD: cfg_in.bit_threshold = csr_chan.wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_min    <= LEADER_MIN_RESET;
         cfg_ff.leader_max    <= LEADER_MAX_RESET;
         cfg_ff.bit_threshold <= BIT_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/ipd_core.sv =====
// ----------------------------------------------------------------------------
// ipd_core
// edge input register, frame state and key code output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipd_core #(
   parameter int CODE_BITS  = 32,
   parameter int STAMP_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ipd_pkg::cfg_type           cfg,
   ipd_req_if.sink                    req_chan,
   ipd_rsp_if.source                  rsp_chan,
   output ipd_pkg::status_type        status
);
   import ipd_pkg::*;

   localparam int CMP_BITS = (STAMP_BITS > CFG_BITS) ? STAMP_BITS : CFG_BITS;
   localparam logic [COUNT_BITS-1:0] LAST_COUNT = COUNT_BITS'(CODE_BITS + 1);

   logic                  s1_valid_ff, s1_valid_in;
   logic [STAMP_BITS-1:0] s1_stamp_ff;
   logic [STAMP_BITS-1:0] prev_ff, prev_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [CODE_BITS-1:0]  shift_ff, shift_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]   key_ff;

   logic                  accept;
   logic                  emit;
   logic                  advance;
   logic [STAMP_BITS-1:0] gap;
   logic [CMP_BITS-1:0]   gap_ext;
   logic                  in_window;
   logic                  data_bit;

   // an emitting edge needs a free output slot, the others never wait
   assign emit    = (count_ff >= LAST_COUNT);
   assign advance = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_chan.ready);
   assign accept  = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || advance;

   assign gap       = prev_ff - s1_stamp_ff;
   assign gap_ext   = CMP_BITS'(gap);
   assign in_window = (gap_ext > CMP_BITS'(cfg.leader_min)) &&
                      (gap_ext < CMP_BITS'(cfg.leader_max));
   assign data_bit  = (gap_ext > CMP_BITS'(cfg.bit_threshold));

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !advance);
      prev_in     = prev_ff;
      count_in    = count_ff;
      shift_in    = shift_ff;
      if (advance) begin
         priority case (1'b1)
            (count_ff == COUNT_IDLE): begin
               prev_in  = s1_stamp_ff;
               shift_in = '0;
               count_in = COUNT_LEADER;
            end
            (count_ff == COUNT_LEADER): begin
               if (in_window) begin
                  prev_in  = s1_stamp_ff;
                  count_in = COUNT_DATA;
               end else begin
                  count_in = COUNT_IDLE;
               end
            end
            default: begin
               shift_in = {shift_ff[CODE_BITS-2:0], data_bit};
               prev_in  = s1_stamp_ff;
               count_in = emit ? COUNT_IDLE : count_ff + COUNT_BITS'(1);
            end
         endcase
      end
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= COUNT_IDLE;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stamp_ff <= req_chan.edge_time;
      end
      shift_ff <= shift_in;
      if (advance && emit) begin
         key_ff <= KEY_BITS'(shift_in);
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.key_code = key_ff;

   assign status.advance    = advance;
   assign status.emit       = emit;
   assign status.edge_count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/ir_pulse_distance_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_unit
// pulse-distance ir frame decoder, one falling-edge stamp per beat
// ----------------------------------------------------------------------------
// Each req beat carries the down-counting timer stamp of one falling edge.
// The unit takes one edge per clock cycle unless stalled: a beat lands in
// an input register and is decoded from there against the frame state, and
// the key code of the frame-closing beat is registered in the output register
// that drives rsp. The only stall comes from the
// output register: the frame-closing edge waits while an earlier key code
// has not been taken. The first edge opens a frame, the second must close a
// leader interval strictly inside leader_min and leader_max (otherwise the
// frame is dropped), and the next CODE_BITS intervals give the code bits,
// first bit most significant, 1 when above bit_threshold. The user must
// write registers on csr only while idle; the unit does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_decoder_unit #(
   parameter int CODE_BITS  = 32,
   parameter int STAMP_BITS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   ipd_req_if.sink   req_chan,
   ipd_rsp_if.source rsp_chan,
   ipd_csr_if.sink   csr_chan
);
   import ipd_pkg::*;

   localparam logic [COUNT_BITS-1:0] LAST_COUNT = COUNT_BITS'(CODE_BITS + 1);

   cfg_type    cfg;
   status_type status;

   ipd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ipd_core #(
      .CODE_BITS  (CODE_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .status   (status)
   );

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      status.edge_count <= LAST_COUNT)
      else $error("edge count beyond last data bit");

   a_idle_after_emit: assert property (@(posedge clock) disable iff (reset)
      (status.advance && status.emit) |=> (status.edge_count == COUNT_IDLE))
      else $error("frame not closed after key code");

   a_open_frame: assert property (@(posedge clock) disable iff (reset)
      (status.advance && (status.edge_count == COUNT_IDLE)) |=>
      (status.edge_count == COUNT_LEADER))
      else $error("first edge did not open a frame");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !(status.advance && status.emit))
      else $error("key code overwritten while held");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_ir_pulse_distance_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_decoder_unit
// self-checking bench for the pulse-distance ir frame decoder
// ----------------------------------------------------------------------------
// Edge stamps are sent one beat at a time. A built-in frame predictor tracks
// the frame position, the last stamp and the gathered code bits, and queues
// the key code that each closing edge should produce. Key code beats are
// compared in order against that queue. A short table of directed rows comes
// first: extreme frames, leader bounds, an empty window and register writes.
// It is followed by random phases under several register settings. Both
// sides idle at random, and one stretch holds off the key code side long
// enough to stall the edge input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ir_pulse_distance_decoder_unit;
   import ipd_pkg::*;

   localparam int STAMP_W       = 24;
   localparam int FRAME_LAST    = KEY_BITS + 1;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_EDGES   = 120;
   localparam int NUM_PHASES    = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int NUM_ROWS      = 22;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef logic [STAMP_W-1:0] stamp_type;
   localparam stamp_type STAMP_MAX = '1;

   typedef enum {ROW_CSR, ROW_EDGE, ROW_FRAME} row_kind_type;
   typedef enum {MODE_NOMINAL, MODE_OPEN, MODE_TIGHT, MODE_EMPTY, MODE_ANY} phase_mode_type;

   // value: register data, edge gap or frame start stamp
   typedef struct {
      row_kind_type                kind;
      logic [CSR_INDEX_BITS-1:0]   index;
      stamp_type                   value;
      stamp_type                   leader;
      stamp_type                   zero_gap;
      stamp_type                   one_gap;
      logic [KEY_BITS-1:0]         bits;
      bit                          pinned;
      logic [KEY_BITS-1:0]         key;
   } stim_row_type;

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{ROW_FRAME, CSR_LEADER_MIN, 24'hFFFFFF, 24'd1075000, 24'd0, 24'hFFFFFF,
        32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_FRAME, CSR_LEADER_MIN, 24'h000000, 24'd1079999, 24'd170000, 24'd170001,
        32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_FRAME, CSR_LEADER_MIN, 24'h800000, 24'd1070001, 24'd170000, 24'd170001,
        32'hA5C3_0F1E, 1'b1, 32'hA5C3_0F1E},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd12345, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd1070000, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd77, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd1080000, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_LEADER_MIN, 24'h000000, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_LEADER_MAX, 24'hFFFFFF, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_BIT_THRESHOLD, 24'h000000, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_SPARE, 24'h5A5A5A, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_FRAME, CSR_LEADER_MIN, 24'h123456, 24'd1, 24'd0, 24'd1,
        32'h5A5A_00FF, 1'b1, 32'h5A5A_00FF},
      '{ROW_FRAME, CSR_LEADER_MIN, 24'h000000, 24'hFFFFFE, 24'd0, 24'hFFFFFF,
        32'h8000_0001, 1'b1, 32'h8000_0001},
      '{ROW_CSR, CSR_BIT_THRESHOLD, 24'hFFFFFF, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_FRAME, CSR_LEADER_MIN, 24'hABCDEF, 24'd500, 24'hFFFFFF, 24'hFFFFFF,
        32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{ROW_CSR, CSR_LEADER_MIN, 24'd5, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_LEADER_MAX, 24'd6, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd0, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd5, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd9, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd6, '0, '0, '0, '0, 1'b0, '0},
      '{ROW_EDGE, CSR_LEADER_MIN, 24'd3, '0, '0, '0, '0, 1'b0, '0}
   };

   phase_mode_type phase_plan [NUM_PHASES] = '{MODE_NOMINAL, MODE_OPEN, MODE_TIGHT,
      MODE_EMPTY, MODE_ANY, MODE_OPEN, MODE_NOMINAL, MODE_ANY};

   logic clock = 1'b0;
   logic reset = 1'b1;

   ipd_req_if #(.STAMP_BITS(STAMP_W)) req_chan ();
   ipd_rsp_if                         rsp_chan ();
   ipd_csr_if                         csr_chan ();

   ir_pulse_distance_decoder_unit #(
      .CODE_BITS  (KEY_BITS),
      .STAMP_BITS (STAMP_W)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // frame predictor state
   cfg_type               cur_cfg;
   logic [COUNT_BITS-1:0] frame_pos;
   stamp_type             last_stamp;
   logic [KEY_BITS-1:0]   code_acc;
   logic [KEY_BITS-1:0]   pending_keys [$];

   bit                    pin_active = 1'b0;
   logic [KEY_BITS-1:0]   pinned_key = '0;
   bit                    burst_mode = 1'b0;
   int                    rsp_hold_cycles = 0;
   stamp_type             drive_stamp = '0;
   int                    edges_sent = 0;
   int                    error_count = 0;
   int                    cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_ir_pulse_distance_decoder_unit: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : frame_predictor
      stamp_type           gap;
      logic [KEY_BITS-1:0] want;
      if (reset) begin
         cur_cfg    = '{leader_min: LEADER_MIN_RESET, leader_max: LEADER_MAX_RESET,
                        bit_threshold: BIT_THRESHOLD_RESET};
         frame_pos  = COUNT_IDLE;
         last_stamp = '0;
         code_acc   = '0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_LEADER_MIN:    cur_cfg.leader_min    = csr_chan.wdata;
               CSR_LEADER_MAX:    cur_cfg.leader_max    = csr_chan.wdata;
               CSR_BIT_THRESHOLD: cur_cfg.bit_threshold = csr_chan.wdata;
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_keys.size() == 0) begin
               $display("%0t: key_code beat with nothing pending, expected none, got %h",
                        $time, rsp_chan.key_code);
               error_count++;
            end else begin
               want = pending_keys.pop_front();
               if (rsp_chan.key_code !== want) begin
                  $display("%0t: key_code mismatch, expected %h, got %h",
                           $time, want, rsp_chan.key_code);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            gap = last_stamp - req_chan.edge_time;
            if (frame_pos == COUNT_IDLE) begin
               last_stamp = req_chan.edge_time;
               code_acc   = '0;
               frame_pos  = COUNT_LEADER;
            end else if (frame_pos == COUNT_LEADER) begin
               // leader must fall strictly inside the window, else drop the edge
               if (gap > cur_cfg.leader_min && gap < cur_cfg.leader_max) begin
                  last_stamp = req_chan.edge_time;
                  frame_pos  = COUNT_DATA;
               end else begin
                  frame_pos = COUNT_IDLE;
               end
            end else begin
               code_acc   = {code_acc[KEY_BITS-2:0], gap > cur_cfg.bit_threshold};
               last_stamp = req_chan.edge_time;
               if (frame_pos >= FRAME_LAST) begin
                  pending_keys.push_back(pin_active ? pinned_key : code_acc);
                  frame_pos = COUNT_IDLE;
               end else begin
                  frame_pos = frame_pos + 1'b1;
               end
            end
         end
      end
   end

   // key code side: random stall per beat, plus one long hold-off on request
   initial begin : key_sink
      int hold;
      rsp_chan.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         hold = burst_mode ? 0 : $urandom_range(0, 4);
         if (rsp_hold_cycles > 0) begin
            hold            = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // valid stays high after a beat; it drops on a gap or an idle wait
   task automatic send_edge(input stamp_type stamp);
      int gap_cycles;
      gap_cycles = burst_mode ? 0 : $urandom_range(0, 4);
      if (gap_cycles > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap_cycles) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.edge_time <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      drive_stamp = stamp;
      edges_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.wdata <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
   endtask

   task automatic idle_until_drained();
      req_chan.valid <= 1'b0;
      while (pending_keys.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // zero-gap edges walk any open frame back to idle
   task automatic flush_frame();
      while (frame_pos != COUNT_IDLE) send_edge(last_stamp);
   endtask

   task automatic settle();
      flush_frame();
      idle_until_drained();
   endtask

   task automatic program_cfg(input stamp_type lo, input stamp_type hi,
                              input stamp_type thr);
      settle();
      write_csr(CSR_LEADER_MIN, lo);
      write_csr(CSR_LEADER_MAX, hi);
      write_csr(CSR_BIT_THRESHOLD, thr);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic stamp_type pick_gap(input bit one);
      int unsigned thr;
      thr = cur_cfg.bit_threshold;
      if (one && thr == STAMP_MAX)
         return stamp_type'($urandom);
      if ($urandom_range(0, 3) == 0)
         return one ? stamp_type'(thr + 1) : stamp_type'(thr);
      if (one)
         return stamp_type'(thr + 1 + ($urandom % (STAMP_MAX - thr)));
      return stamp_type'($urandom % (thr + 1));
   endfunction

   function automatic stamp_type pick_leader(input bit in_window);
      int unsigned lo;
      int unsigned hi;
      lo = cur_cfg.leader_min;
      hi = cur_cfg.leader_max;
      if (in_window && hi > lo + 1) begin
         case ($urandom_range(0, 3))
            0:       return stamp_type'(lo + 1);
            1:       return stamp_type'(hi - 1);
            default: return stamp_type'(lo + 1 + ($urandom % (hi - lo - 1)));
         endcase
      end
      case ($urandom_range(0, 2))
         0:       return stamp_type'(lo);
         1:       return stamp_type'(hi);
         default: return stamp_type'($urandom);
      endcase
   endfunction

   task automatic send_frame(input stamp_type start, input stamp_type leader,
                             input logic [KEY_BITS-1:0] bits, input int n_bits,
                             input bit vary, input stamp_type zero_gap,
                             input stamp_type one_gap);
      stamp_type stamp;
      bit        one;
      stamp = start;
      send_edge(stamp);
      stamp = stamp - leader;
      send_edge(stamp);
      for (int i = 0; i < n_bits; i++) begin
         one   = bits[KEY_BITS-1-i];
         stamp = stamp - (vary ? pick_gap(one) : (one ? one_gap : zero_gap));
         send_edge(stamp);
      end
   endtask

   initial begin : stimulus
      phase_mode_type mode;
      stamp_type      lo;
      stamp_type      hi;
      stamp_type      thr;
      int             phase_start;

      req_chan.valid     = 1'b0;
      req_chan.edge_time = '0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.wdata     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_CSR: begin
               settle();
               write_csr(directed_rows[r].index, directed_rows[r].value);
               csr_chan.valid <= 1'b0;
            end
            ROW_EDGE: begin
               send_edge(drive_stamp - directed_rows[r].value);
            end
            default: begin
               flush_frame();
               pin_active = directed_rows[r].pinned;
               pinned_key = directed_rows[r].key;
               send_frame(directed_rows[r].value, directed_rows[r].leader,
                          directed_rows[r].bits, KEY_BITS, 1'b0,
                          directed_rows[r].zero_gap, directed_rows[r].one_gap);
               pin_active = 1'b0;
            end
         endcase
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         mode = phase_plan[phase];
         case (mode)
            MODE_NOMINAL: begin
               lo  = LEADER_MIN_RESET;
               hi  = LEADER_MAX_RESET;
               thr = BIT_THRESHOLD_RESET;
            end
            MODE_OPEN: begin
               lo  = '0;
               hi  = STAMP_MAX;
               thr = (phase < 4) ? stamp_type'(0) : stamp_type'($urandom_range(0, 1000000));
            end
            MODE_TIGHT: begin
               lo  = stamp_type'($urandom_range(0, STAMP_MAX - 16));
               hi  = lo + 2;
               thr = stamp_type'($urandom);
            end
            MODE_EMPTY: begin
               lo  = stamp_type'($urandom_range(1, STAMP_MAX));
               hi  = stamp_type'($urandom_range(0, (lo < STAMP_MAX) ? lo + 1 : lo));
               thr = stamp_type'($urandom);
            end
            default: begin
               lo  = stamp_type'($urandom);
               hi  = stamp_type'($urandom);
               thr = stamp_type'($urandom);
            end
         endcase
         program_cfg(lo, hi, thr);
         phase_start = edges_sent;
         while (edges_sent - phase_start < PHASE_EDGES) begin
            burst_mode = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  flush_frame();
                  send_frame(stamp_type'($urandom), pick_leader(1'b1), $urandom,
                             KEY_BITS, 1'b1, '0, '0);
               end
               6: send_frame(stamp_type'($urandom), pick_leader(1'b1), $urandom,
                             $urandom_range(0, KEY_BITS - 1), 1'b1, '0, '0);
               7: send_frame(stamp_type'($urandom), pick_leader(1'b0), $urandom,
                             $urandom_range(0, 3), 1'b1, '0, '0);
               8: repeat ($urandom_range(1, 6)) send_edge(stamp_type'($urandom));
               default: begin
                  if ($urandom_range(0, 3) == 0)
                     idle_until_drained();
                  else
                     send_edge(stamp_type'($urandom));
               end
            endcase
         end
         burst_mode = 1'b0;
      end

      // key code side holds off while back-to-back frames pile up behind it
      program_cfg(LEADER_MIN_RESET, LEADER_MAX_RESET, BIT_THRESHOLD_RESET);
      burst_mode      = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (6) send_frame(stamp_type'($urandom), pick_leader(1'b1), $urandom,
                            KEY_BITS, 1'b1, '0, '0);
      burst_mode = 1'b0;

      idle_until_drained();
      if (error_count == 0)
         $display("tb_ir_pulse_distance_decoder_unit: PASS");
      else
         $display("tb_ir_pulse_distance_decoder_unit: FAIL");
      $finish;
   end

endmodule
